// File: src/caw_pkg.sv
package caw_pkg;

    localparam int MAX_CIGAR_OPS_DEF = 64;
    localparam int MAX_READ_LEN_DEF  = 1024;
    localparam logic [7:0] QOFF_RESET = 8'd33;
    localparam logic [10:0] SEQ_LIMIT = 11'd2047;
    localparam logic [7:0] GAP_CHAR = 8'h2D;   // '-'

    // input opcodes
    localparam logic [2:0] OPC_HEADER = 3'd0;
    localparam logic [2:0] OPC_LOAD_OP = 3'd1;
    localparam logic [2:0] OPC_LOAD_BASE = 3'd2;
    localparam logic [2:0] OPC_BEGIN = 3'd3;
    localparam logic [2:0] OPC_GO = 3'd4;
    localparam logic [2:0] OPC_NEXT_INDEL = 3'd5;

    // cigar operation kinds
    localparam logic [3:0] OP_M = 4'd0;
    localparam logic [3:0] OP_I = 4'd1;
    localparam logic [3:0] OP_D = 4'd2;
    localparam logic [3:0] OP_N = 4'd3;
    localparam logic [3:0] OP_S = 4'd4;
    localparam logic [3:0] OP_H = 4'd5;
    localparam logic [3:0] OP_P = 4'd6;
    localparam logic [3:0] OP_EQ = 4'd7;
    localparam logic [3:0] OP_X = 4'd8;

    // strand codes
    localparam logic [1:0] STR_UNK = 2'd0;
    localparam logic [1:0] STR_FWD = 2'd1;
    localparam logic [1:0] STR_REV = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BACKWARD = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_INDEL_EARLY = 2'd3;

    // datapath commands
    localparam logic [3:0] CMD_NONE = 4'd0;
    localparam logic [3:0] CMD_HEADER = 4'd1;
    localparam logic [3:0] CMD_LOAD_OP = 4'd2;
    localparam logic [3:0] CMD_LOAD_BASE = 4'd3;
    localparam logic [3:0] CMD_BEGIN_INIT = 4'd4;
    localparam logic [3:0] CMD_BEGIN_STEP = 4'd5;
    localparam logic [3:0] CMD_BEGIN_FIN = 4'd6;
    localparam logic [3:0] CMD_GO_INIT = 4'd7;
    localparam logic [3:0] CMD_WALK_STEP = 4'd8;
    localparam logic [3:0] CMD_TAIL_STEP = 4'd9;
    localparam logic [3:0] CMD_TAIL_END = 4'd10;
    localparam logic [3:0] CMD_NI_INIT = 4'd11;
    localparam logic [3:0] CMD_NI_STEP = 4'd12;
    localparam logic [3:0] CMD_EMIT = 4'd13;

    // result kinds
    localparam logic [2:0] EK_ZERO = 3'd0;
    localparam logic [2:0] EK_REPORT = 3'd1;
    localparam logic [2:0] EK_BACK = 3'd2;
    localparam logic [2:0] EK_NI_NONE = 3'd3;
    localparam logic [2:0] EK_NI_ERR = 3'd4;
    localparam logic [2:0] EK_NI_FOUND = 3'd5;

    typedef struct packed {
        logic [3:0]  op_type;
        logic [27:0] op_length;
        logic [7:0]  base_char;
        logic [7:0]  qual_char;
        logic [30:0] genome_pos;
        logic [10:0] read_len;
        logic        paired;
        logic        proper_pair;
        logic        first_mate;
        logic        second_mate;
        logic        reverse_strand;
    } item_t;

    typedef struct packed {
        logic [7:0]  base_or_gap;
        logic [8:0]  quality;
        logic [11:0] dist_five;
        logic [11:0] dist_three;
        logic        at_end;
        logic        saw_indel;
        logic        indel_found;
        logic        indel_insertion;
        logic [27:0] indel_size;
        logic [31:0] indel_genome_pos;
        logic        indel_reverse;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic       latch;
        logic [3:0] code;
        logic [2:0] ekind;
    } cmd_t;

    typedef struct packed {
        logic       op_avail;
        logic       at_count;
        logic       count_zero;
        logic       backward;
        logic       strand_unk;
        logic       parsing;
        logic [3:0] kind;
        logic       out_free;
    } stat_t;

    function automatic logic is_match(input logic [3:0] k);
        return (k == OP_M) || (k == OP_EQ) || (k == OP_X);
    endfunction

    function automatic logic [10:0] seq_add(input logic [10:0] s, input logic [31:0] n);
        logic [32:0] sum;
        sum = 33'(s) + 33'(n);
        return (sum > 33'(SEQ_LIMIT)) ? SEQ_LIMIT : sum[10:0];
    endfunction

    function automatic logic [11:0] sat12(input logic signed [29:0] v);
        if (v < -30'sd2048)
            return 12'h800;
        else if (v > 30'sd2047)
            return 12'h7FF;
        else
            return v[11:0];
    endfunction

endpackage

// File: src/caw_ram.sv
module caw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: src/caw_ctrl.sv
module caw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [2:0]     opcode,
    input  caw_pkg::stat_t st,
    output caw_pkg::cmd_t  cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_BWAIT = 4'd2;
    localparam logic [3:0] S_BEXEC = 4'd3;
    localparam logic [3:0] S_WWAIT = 4'd4;
    localparam logic [3:0] S_WEXEC = 4'd5;
    localparam logic [3:0] S_TWAIT = 4'd6;
    localparam logic [3:0] S_TEXEC = 4'd7;
    localparam logic [3:0] S_NWAIT = 4'd8;
    localparam logic [3:0] S_NEXEC = 4'd9;
    localparam logic [3:0] S_RWAIT = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] opc_reg, opc_next;
    logic [2:0] ek_reg, ek_next;
    logic       tail_more;

    assign s_tready = (state_reg == S_IDLE);
    assign tail_more = st.op_avail && (st.kind == caw_pkg::OP_P || st.kind == caw_pkg::OP_I);

    always_comb
    begin
        state_next = state_reg;
        opc_next = opc_reg;
        ek_next = ek_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch = 1'b1;
                    opc_next = opcode;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                ek_next = caw_pkg::EK_ZERO;
                state_next = S_EMIT;
                unique case (opc_reg)
                    caw_pkg::OPC_HEADER: cmd.code = caw_pkg::CMD_HEADER;
                    caw_pkg::OPC_LOAD_OP: cmd.code = caw_pkg::CMD_LOAD_OP;
                    caw_pkg::OPC_LOAD_BASE: cmd.code = caw_pkg::CMD_LOAD_BASE;
                    caw_pkg::OPC_BEGIN:
                    begin
                        cmd.code = caw_pkg::CMD_BEGIN_INIT;
                        state_next = S_BWAIT;
                    end
                    caw_pkg::OPC_GO:
                    begin
                        if (st.backward)
                        begin
                            ek_next = caw_pkg::EK_BACK;
                            state_next = S_RWAIT;
                        end
                        else
                        begin
                            cmd.code = caw_pkg::CMD_GO_INIT;
                            state_next = S_WWAIT;
                        end
                    end
                    caw_pkg::OPC_NEXT_INDEL:
                    begin
                        if (st.strand_unk)
                        begin
                            ek_next = caw_pkg::EK_NI_NONE;
                        end
                        else if (!st.parsing && !st.at_count)
                        begin
                            ek_next = caw_pkg::EK_NI_ERR;
                        end
                        else
                        begin
                            if (!st.parsing)
                            begin
                                cmd.code = caw_pkg::CMD_NI_INIT;
                            end
                            state_next = S_NWAIT;
                        end
                    end
                    default: ;   // unused opcodes answer an all-zero result
                endcase
            end
            S_BWAIT: state_next = S_BEXEC;
            S_BEXEC:
            begin
                if (st.op_avail && (st.kind == caw_pkg::OP_I || st.kind == caw_pkg::OP_S ||
                                    st.kind == caw_pkg::OP_P))
                begin
                    cmd.code = caw_pkg::CMD_BEGIN_STEP;
                    state_next = S_BWAIT;
                end
                else
                begin
                    cmd.code = caw_pkg::CMD_BEGIN_FIN;
                    ek_next = caw_pkg::EK_REPORT;
                    state_next = S_RWAIT;
                end
            end
            S_WWAIT: state_next = S_WEXEC;
            S_WEXEC, S_TEXEC:
            begin
                if (state_reg == S_WEXEC && !st.count_zero && st.op_avail)
                begin
                    cmd.code = caw_pkg::CMD_WALK_STEP;
                    state_next = S_WWAIT;
                end
                else if (tail_more)
                begin
                    cmd.code = caw_pkg::CMD_TAIL_STEP;
                    state_next = S_TWAIT;
                end
                else
                begin
                    cmd.code = caw_pkg::CMD_TAIL_END;
                    ek_next = caw_pkg::EK_REPORT;
                    state_next = S_RWAIT;
                end
            end
            S_TWAIT: state_next = S_TEXEC;
            S_NWAIT: state_next = S_NEXEC;
            S_NEXEC:
            begin
                if (st.op_avail && st.kind != caw_pkg::OP_I && st.kind != caw_pkg::OP_D)
                begin
                    cmd.code = caw_pkg::CMD_NI_STEP;
                    state_next = S_NWAIT;
                end
                else
                begin
                    ek_next = st.op_avail ? caw_pkg::EK_NI_FOUND : caw_pkg::EK_NI_NONE;
                    state_next = S_EMIT;
                end
            end
            S_RWAIT: state_next = S_EMIT;
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.code = caw_pkg::CMD_EMIT;
                    cmd.ekind = ek_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            opc_reg <= '0;
            ek_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            opc_reg <= opc_next;
            ek_reg <= ek_next;
        end
    end

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == caw_pkg::CMD_EMIT) |-> st.out_free)
        else $error("result written while output busy");

    a_latch_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |-> (state_reg == S_IDLE) && s_tvalid)
        else $error("request latched outside idle");
endmodule

// File: src/caw_datapath.sv
module caw_datapath #(
    parameter int MAX_CIGAR_OPS = caw_pkg::MAX_CIGAR_OPS_DEF,
    parameter int MAX_READ_LEN  = caw_pkg::MAX_READ_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  caw_pkg::item_t   item,
    input  logic [7:0]       qoff,
    input  caw_pkg::cmd_t    cmd,
    output caw_pkg::stat_t   st,
    input  logic             m_tready,
    output logic             m_tvalid,
    output caw_pkg::result_t res
);
    localparam int OCW = $clog2(MAX_CIGAR_OPS + 1);
    localparam int OAW = (MAX_CIGAR_OPS > 1) ? $clog2(MAX_CIGAR_OPS) : 1;
    localparam int BCW = $clog2(MAX_READ_LEN + 1);
    localparam int BAW = (MAX_READ_LEN > 1) ? $clog2(MAX_READ_LEN) : 1;
    localparam int XW  = (BCW > 11) ? BCW : 11;

    caw_pkg::item_t   it_reg;
    caw_pkg::result_t res_reg, res_next;
    logic             rvalid_reg, rvalid_next;
    logic [OCW-1:0]   ocnt_reg, ocnt_next, oidx_reg, oidx_next;
    logic [BCW-1:0]   bcnt_reg, bcnt_next;
    logic [27:0]      woc_reg, woc_next;
    logic [10:0]      seq_reg, seq_next;
    logic [31:0]      cur_reg, cur_next, cnt_reg, cnt_next;
    logic [30:0]      start_reg, start_next;
    logic [10:0]      rlen_reg, rlen_next;
    logic             end_reg, end_next, indel_reg, indel_next;
    logic             ign5_reg, ign5_next, ign3_reg, ign3_next, parse_reg, parse_next;
    logic [1:0]       strand_reg, strand_next;

    logic [31:0]      op_rd;
    logic [15:0]      base_rd;
    logic [3:0]       kind;
    logic [27:0]      olen;
    logic             op_avail, valid_op, base_valid, ins;
    logic [XW-1:0]    seq_x;
    logic [27:0]      r;
    logic [31:0]      n;
    logic [28:0]      wsum;
    logic signed [12:0] lm13, lb13;
    logic [11:0]      ds, dl, rep_d5, rep_d3, nb, ni_d3s;
    caw_pkg::result_t rep;

    // stores
    caw_ram #(.WIDTH(32), .DEPTH(MAX_CIGAR_OPS)) u_op_ram (
        .clk   (clk),
        .we    (cmd.code == caw_pkg::CMD_LOAD_OP && ocnt_reg < OCW'(MAX_CIGAR_OPS)),
        .waddr (ocnt_reg[OAW-1:0]),
        .wdata ({it_reg.op_length, it_reg.op_type}),
        .raddr (oidx_reg[OAW-1:0]),
        .rdata (op_rd)
    );

    caw_ram #(.WIDTH(16), .DEPTH(MAX_READ_LEN)) u_base_ram (
        .clk   (clk),
        .we    (cmd.code == caw_pkg::CMD_LOAD_BASE && bcnt_reg < BCW'(MAX_READ_LEN)),
        .waddr (bcnt_reg[BAW-1:0]),
        .wdata ({it_reg.qual_char, it_reg.base_char}),
        .raddr (seq_x[BAW-1:0]),
        .rdata (base_rd)
    );

    assign kind = op_rd[3:0];
    assign olen = op_rd[31:4];
    assign op_avail = oidx_reg < ocnt_reg;
    assign valid_op = !end_reg && op_avail;
    assign seq_x = XW'(seq_reg);
    assign base_valid = seq_x < XW'(bcnt_reg);
    assign ins = (kind == caw_pkg::OP_I);

    assign st.op_avail = op_avail;
    assign st.at_count = (oidx_reg == ocnt_reg);
    assign st.count_zero = (cnt_reg == '0);
    assign st.backward = {1'b0, it_reg.genome_pos} < cur_reg;
    assign st.strand_unk = (strand_reg == caw_pkg::STR_UNK);
    assign st.parsing = parse_reg;
    assign st.kind = kind;
    assign st.out_free = !rvalid_reg || m_tready;

    // walk step arithmetic
    assign r = (olen > woc_reg) ? (olen - woc_reg) : 28'd1;
    assign n = (32'(r) < cnt_reg) ? 32'(r) : cnt_reg;
    assign wsum = {1'b0, woc_reg} + {1'b0, n[27:0]};

    // distances; both fit 12 bits without clamping
    assign lm13 = $signed({2'b0, rlen_reg}) - 13'sd1 - $signed({2'b0, seq_reg});
    assign lb13 = $signed({2'b0, rlen_reg}) - $signed({2'b0, seq_reg});
    assign ds = {1'b0, seq_reg};
    assign dl = lm13[11:0];
    assign nb = lb13[11:0];
    assign ni_d3s = caw_pkg::sat12($signed({19'b0, rlen_reg}) - $signed({19'b0, seq_reg})
                                   - $signed({2'b0, olen}));

    always_comb
    begin
        if (ign5_reg)
            rep_d5 = 12'hFFF;
        else if (strand_reg == caw_pkg::STR_FWD)
            rep_d5 = ds;
        else if (strand_reg == caw_pkg::STR_REV)
            rep_d5 = dl;
        else
            rep_d5 = 12'hFFF;
        if (ign3_reg)
            rep_d3 = 12'hFFF;
        else if (strand_reg == caw_pkg::STR_REV)
            rep_d3 = ds;
        else if (strand_reg == caw_pkg::STR_FWD)
            rep_d3 = dl;
        else
            rep_d3 = 12'hFFF;
    end

    always_comb
    begin
        rep = '0;
        rep.dist_five = rep_d5;
        rep.dist_three = rep_d3;
        if (valid_op)
        begin
            if (kind == caw_pkg::OP_D || kind == caw_pkg::OP_N)
            begin
                rep.base_or_gap = caw_pkg::GAP_CHAR;
            end
            else if (caw_pkg::is_match(kind))
            begin
                if (base_valid)
                begin
                    rep.base_or_gap = base_rd[7:0];
                    rep.quality = {1'b0, base_rd[15:8]} - {1'b0, qoff};
                end
            end
            else if (kind != caw_pkg::OP_H)
            begin
                rep.status = caw_pkg::ST_ILLEGAL;
            end
        end
    end

    always_comb
    begin
        ocnt_next = ocnt_reg;
        oidx_next = oidx_reg;
        bcnt_next = bcnt_reg;
        woc_next = woc_reg;
        seq_next = seq_reg;
        cur_next = cur_reg;
        cnt_next = cnt_reg;
        start_next = start_reg;
        rlen_next = rlen_reg;
        end_next = end_reg;
        indel_next = indel_reg;
        ign5_next = ign5_reg;
        ign3_next = ign3_reg;
        parse_next = parse_reg;
        strand_next = strand_reg;
        res_next = res_reg;
        rvalid_next = rvalid_reg && !m_tready;
        unique case (cmd.code)
            caw_pkg::CMD_HEADER:
            begin
                start_next = it_reg.genome_pos;
                rlen_next = it_reg.read_len;
                ocnt_next = '0;
                bcnt_next = '0;
                oidx_next = '0;
                woc_next = '0;
                seq_next = '0;
                cur_next = {1'b0, it_reg.genome_pos};
                {end_next, indel_next, ign5_next, ign3_next, parse_next} = '0;
                strand_next = caw_pkg::STR_UNK;
            end
            caw_pkg::CMD_LOAD_OP:
            begin
                if (ocnt_reg < OCW'(MAX_CIGAR_OPS))
                    ocnt_next = ocnt_reg + 1'b1;
            end
            caw_pkg::CMD_LOAD_BASE:
            begin
                if (bcnt_reg < BCW'(MAX_READ_LEN))
                    bcnt_next = bcnt_reg + 1'b1;
            end
            caw_pkg::CMD_BEGIN_INIT:
            begin
                oidx_next = '0;
                woc_next = '0;
                seq_next = '0;
                cur_next = {1'b0, start_reg};
                {end_next, indel_next, ign5_next, ign3_next, parse_next} = '0;
                strand_next = caw_pkg::STR_UNK;
            end
            caw_pkg::CMD_BEGIN_STEP:
            begin
                if (kind == caw_pkg::OP_I)
                    indel_next = 1'b1;
                if (kind != caw_pkg::OP_P)
                    seq_next = caw_pkg::seq_add(seq_reg, 32'(olen));
                oidx_next = oidx_reg + 1'b1;
            end
            caw_pkg::CMD_BEGIN_FIN:
            begin
                if (!op_avail)
                    end_next = 1'b1;
                if (it_reg.paired && it_reg.proper_pair)
                begin
                    if (it_reg.first_mate)
                    begin
                        ign3_next = 1'b1;
                        strand_next = it_reg.reverse_strand ? caw_pkg::STR_REV
                                                            : caw_pkg::STR_FWD;
                    end
                    else if (it_reg.second_mate)
                    begin
                        ign5_next = 1'b1;
                        strand_next = it_reg.reverse_strand ? caw_pkg::STR_FWD
                                                            : caw_pkg::STR_REV;
                    end
                end
                else if (!it_reg.paired)
                begin
                    strand_next = it_reg.reverse_strand ? caw_pkg::STR_REV : caw_pkg::STR_FWD;
                end
            end
            caw_pkg::CMD_GO_INIT:
            begin
                cnt_next = {1'b0, it_reg.genome_pos} - cur_reg;
            end
            caw_pkg::CMD_WALK_STEP:
            begin
                if (caw_pkg::is_match(kind) || kind == caw_pkg::OP_D ||
                    kind == caw_pkg::OP_N || kind == caw_pkg::OP_H)
                begin
                    if (caw_pkg::is_match(kind))
                        seq_next = caw_pkg::seq_add(seq_reg, n);
                    if (kind == caw_pkg::OP_D)
                        indel_next = 1'b1;
                    cur_next = cur_reg + n;
                    cnt_next = cnt_reg - n;
                    if (wsum >= {1'b0, olen})
                    begin
                        woc_next = '0;
                        oidx_next = oidx_reg + 1'b1;
                    end
                    else
                    begin
                        woc_next = wsum[27:0];
                    end
                end
                else
                begin
                    if (kind == caw_pkg::OP_I || kind == caw_pkg::OP_S)
                        seq_next = caw_pkg::seq_add(seq_reg, 32'(r));
                    if (kind == caw_pkg::OP_I)
                        indel_next = 1'b1;
                    woc_next = '0;
                    oidx_next = oidx_reg + 1'b1;
                end
            end
            caw_pkg::CMD_TAIL_STEP:
            begin
                if (kind == caw_pkg::OP_I)
                begin
                    indel_next = 1'b1;
                    seq_next = caw_pkg::seq_add(seq_reg, 32'(olen));
                end
                oidx_next = oidx_reg + 1'b1;
            end
            caw_pkg::CMD_TAIL_END:
            begin
                if (!op_avail)
                begin
                    end_next = 1'b1;
                end
                else if (kind == caw_pkg::OP_S || kind == caw_pkg::OP_H)
                begin
                    oidx_next = ocnt_reg;
                    end_next = 1'b1;
                end
            end
            caw_pkg::CMD_NI_INIT:
            begin
                parse_next = 1'b1;
                oidx_next = '0;
                seq_next = '0;
                cur_next = {1'b0, start_reg};
            end
            caw_pkg::CMD_NI_STEP:
            begin
                if (caw_pkg::is_match(kind) || kind == caw_pkg::OP_S)
                    seq_next = caw_pkg::seq_add(seq_reg, 32'(olen));
                if (caw_pkg::is_match(kind) || kind == caw_pkg::OP_N || kind == caw_pkg::OP_H)
                    cur_next = cur_reg + 32'(olen);
                oidx_next = oidx_reg + 1'b1;
            end
            caw_pkg::CMD_EMIT:
            begin
                rvalid_next = 1'b1;
                res_next = '0;
                unique case (cmd.ekind)
                    caw_pkg::EK_REPORT, caw_pkg::EK_BACK:
                    begin
                        if (valid_op && kind == caw_pkg::OP_D)
                            indel_next = 1'b1;
                        res_next = rep;
                        if (cmd.ekind == caw_pkg::EK_BACK)
                            res_next.status = caw_pkg::ST_BACKWARD;
                        res_next.at_end = end_reg;
                        res_next.saw_indel = indel_next;
                    end
                    caw_pkg::EK_NI_NONE, caw_pkg::EK_NI_ERR:
                    begin
                        res_next.dist_five = 12'hFFF;
                        res_next.dist_three = 12'hFFF;
                        res_next.at_end = end_reg;
                        res_next.saw_indel = indel_reg;
                        if (cmd.ekind == caw_pkg::EK_NI_ERR)
                            res_next.status = caw_pkg::ST_INDEL_EARLY;
                    end
                    caw_pkg::EK_NI_FOUND:
                    begin
                        res_next.indel_found = 1'b1;
                        res_next.indel_insertion = ins;
                        res_next.indel_size = olen;
                        res_next.indel_genome_pos = cur_reg;
                        res_next.indel_reverse = (strand_reg == caw_pkg::STR_REV);
                        res_next.at_end = end_reg;
                        res_next.saw_indel = indel_reg;
                        if (ins)
                        begin
                            res_next.dist_five = ds;
                            res_next.dist_three = ni_d3s;
                            seq_next = caw_pkg::seq_add(seq_reg, 32'(olen));
                        end
                        else
                        begin
                            res_next.dist_five = (strand_reg == caw_pkg::STR_FWD) ? ds : nb;
                            res_next.dist_three = (strand_reg == caw_pkg::STR_FWD) ? nb : ds;
                            cur_next = cur_reg + 32'(olen);
                        end
                        oidx_next = oidx_reg + 1'b1;
                    end
                    default: ;   // all-zero result
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            it_reg <= item;
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
            ocnt_reg <= '0;
            oidx_reg <= '0;
            bcnt_reg <= '0;
            woc_reg <= '0;
            seq_reg <= '0;
            cur_reg <= '0;
            cnt_reg <= '0;
            start_reg <= '0;
            rlen_reg <= '0;
            end_reg <= 1'b0;
            indel_reg <= 1'b0;
            ign5_reg <= 1'b0;
            ign3_reg <= 1'b0;
            parse_reg <= 1'b0;
            strand_reg <= caw_pkg::STR_UNK;
        end
        else
        begin
            rvalid_reg <= rvalid_next;
            ocnt_reg <= ocnt_next;
            oidx_reg <= oidx_next;
            bcnt_reg <= bcnt_next;
            woc_reg <= woc_next;
            seq_reg <= seq_next;
            cur_reg <= cur_next;
            cnt_reg <= cnt_next;
            start_reg <= start_next;
            rlen_reg <= rlen_next;
            end_reg <= end_next;
            indel_reg <= indel_next;
            ign5_reg <= ign5_next;
            ign3_reg <= ign3_next;
            parse_reg <= parse_next;
            strand_reg <= strand_next;
        end
    end

    assign m_tvalid = rvalid_reg;
    assign res = res_reg;

    a_idx_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        oidx_reg <= ocnt_reg)
        else $error("op index beyond op count");

    a_parse_has_strand: assert property (@(posedge clk) disable iff (!rst_n)
        parse_reg |-> (strand_reg != caw_pkg::STR_UNK))
        else $error("indel parse without known strand");

    a_walk_no_overshoot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.code == caw_pkg::CMD_WALK_STEP) |=> (cnt_reg <= $past(cnt_reg)))
        else $error("walk count grew");
endmodule

// File: src/cigar_alignment_walker.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser opcode, s_tdata item fields
// m_*       out  m_tvalid/m_tready  m_tdata result fields
// APB       in   psel/penable       quality_offset at byte address 0
//
// One request at a time. Loads and header pass through dispatch and emit to a result.
// Begin, go and next-indel walk the CIGAR list with a wait and an execute state per
// operation (one op-store read, one update), plus dispatch and report states.
// A go moves a whole run of a matching op in one step, so its cost is the
// number of ops crossed, not the number of bases.
// rst_n clears all control and counters; the stores hold garbage until loaded.
// A result waits in the output register; a new request is taken meanwhile, and
// only its own result write waits for m_tready.
module cigar_alignment_walker #(
    parameter int MAX_CIGAR_OPS = caw_pkg::MAX_CIGAR_OPS_DEF,
    parameter int MAX_READ_LEN  = caw_pkg::MAX_READ_LEN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [95:0] op_type[3:0], op_length[31:4], base_char[39:32], qual_char[47:40],
    // genome_pos[78:48], read_len[89:79], paired 90, proper_pair 91,
    // first_mate 92, second_mate 93, reverse_strand 94, zero 95
    input  logic [95:0]  s_tdata,
    // opcode[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [111:0] base_or_gap[7:0], quality[16:8], dist_five[28:17],
    // dist_three[40:29], at_end 41, saw_indel 42, indel_found 43,
    // indel_insertion 44, indel_size[72:45], indel_genome_pos[104:73],
    // indel_reverse 105, status[107:106], zero[111:108]
    output logic [111:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    caw_pkg::item_t   item;
    caw_pkg::result_t res;
    caw_pkg::cmd_t    cmd;
    caw_pkg::stat_t   st;
    logic [7:0]       qoff_reg;

    // register file: one register, quality_offset at address 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'b0, qoff_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qoff_reg <= caw_pkg::QOFF_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            qoff_reg <= pwdata[7:0];
        end
    end

    // unpack request
    assign item.op_type = s_tdata[3:0];
    assign item.op_length = s_tdata[31:4];
    assign item.base_char = s_tdata[39:32];
    assign item.qual_char = s_tdata[47:40];
    assign item.genome_pos = s_tdata[78:48];
    assign item.read_len = s_tdata[89:79];
    assign item.paired = s_tdata[90];
    assign item.proper_pair = s_tdata[91];
    assign item.first_mate = s_tdata[92];
    assign item.second_mate = s_tdata[93];
    assign item.reverse_strand = s_tdata[94];

    caw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .st       (st),
        .cmd      (cmd)
    );

    caw_datapath #(
        .MAX_CIGAR_OPS (MAX_CIGAR_OPS),
        .MAX_READ_LEN  (MAX_READ_LEN)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .qoff     (qoff_reg),
        .cmd      (cmd),
        .st       (st),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res      (res)
    );

    // pack result
    assign m_tdata = {4'b0, res.status, res.indel_reverse, res.indel_genome_pos,
                      res.indel_size, res.indel_insertion, res.indel_found,
                      res.saw_indel, res.at_end, res.dist_three, res.dist_five,
                      res.quality, res.base_or_gap};
endmodule

// File: bench/tb_cigar_alignment_walker.sv
`timescale 1ns / 100ps

// Bench for cigar_alignment_walker. Each request sent on the s_ stream is run
// through a local model of the read store and walker, and its expected result
// is queued. Results from the m_ stream are compared field by field, in order.
// Directed checks come first. Then a full-store check, then random reads run
// under three idle patterns, with quality_offset rewritten between phases.
module tb_cigar_alignment_walker;

    localparam int unsigned RUN_LIMIT = 3_000_000;
    localparam int unsigned OPS_MAX = 64;
    localparam int unsigned BASES_MAX = 1024;
    // opcodes with no function; the block answers all-zero
    localparam logic [2:0] OPC_SPARE6 = 3'd6;
    localparam logic [2:0] OPC_SPARE7 = 3'd7;
    localparam logic [2:0] PADDR_QOFF = 3'd0;
    // op kind with no meaning
    localparam logic [3:0] OP_UNKNOWN = 4'd9;

    typedef struct {
        logic [2:0]  opc;
        logic [3:0]  kind;
        logic [27:0] len;
        logic [7:0]  base;
        logic [7:0]  qual;
        logic [30:0] gpos;
        logic [10:0] rlen;
        logic        paired;
        logic        proper;
        logic        first;
        logic        second;
        logic        rev;
    } request_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    cigar_alignment_walker DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // walker model state
    logic [3:0]       op_kinds [OPS_MAX];
    logic [27:0]      op_lens [OPS_MAX];
    logic [7:0]       read_bases [BASES_MAX];
    logic [7:0]       read_quals [BASES_MAX];
    int unsigned      n_ops, n_bases, cur_op, seq_pos;
    longint unsigned  in_op;
    logic [31:0]      cursor;
    logic [30:0]      start_pos;
    int unsigned      read_length;
    bit               at_end_f, indel_f, ign5_f, ign3_f, parse_f;
    logic [1:0]       strand;
    logic [7:0]       qoff = caw_pkg::QOFF_RESET;
    caw_pkg::result_t want;

    caw_pkg::result_t expected_results [$];
    int unsigned      errors = 0;
    int unsigned      cycles = 0;
    int unsigned      items_sent = 0;
    int unsigned      src_idle_pct = 0;
    int unsigned      snk_idle_pct = 0;

    function automatic bit is_match_kind(logic [3:0] k);
        return k == caw_pkg::OP_M || k == caw_pkg::OP_EQ || k == caw_pkg::OP_X;
    endfunction

    // sequence index saturates at 2047
    function automatic int unsigned seq_advance(int unsigned a, longint unsigned n);
        longint unsigned s;
        s = a + n;
        return (s > 2047) ? 2047 : int'(s);
    endfunction

    function automatic logic [11:0] clamp12(longint v);
        if (v < -2048)
            return 12'h800;
        if (v > 2047)
            return 12'h7FF;
        return v[11:0];
    endfunction

    // what the walker shows at its current spot; fills want, returns status
    function automatic logic [1:0] look_here();
        longint len;
        longint s;
        logic [1:0] st;
        logic [3:0] t;
        len = read_length;
        s = seq_pos;
        st = caw_pkg::ST_OK;
        if (!at_end_f && cur_op < n_ops)
        begin
            t = op_kinds[cur_op];
            if (t == caw_pkg::OP_D || t == caw_pkg::OP_N)
            begin
                if (t == caw_pkg::OP_D)
                    indel_f = 1;
                want.base_or_gap = caw_pkg::GAP_CHAR;
            end
            else if (is_match_kind(t))
            begin
                if (seq_pos < n_bases)
                begin
                    want.base_or_gap = read_bases[seq_pos];
                    want.quality = 9'(int'(read_quals[seq_pos]) - int'(qoff));
                end
            end
            else if (t != caw_pkg::OP_H)
                st = caw_pkg::ST_ILLEGAL;
        end
        want.dist_five = ign5_f ? clamp12(-1)
                       : strand == caw_pkg::STR_FWD ? clamp12(s)
                       : strand == caw_pkg::STR_REV ? clamp12(len - 1 - s) : clamp12(-1);
        want.dist_three = ign3_f ? clamp12(-1)
                        : strand == caw_pkg::STR_REV ? clamp12(s)
                        : strand == caw_pkg::STR_FWD ? clamp12(len - 1 - s) : clamp12(-1);
        return st;
    endfunction

    function automatic void walk_forward(longint unsigned count);
        logic [3:0] t;
        longint unsigned l, r, n;
        while (count > 0 && cur_op < n_ops)
        begin
            t = op_kinds[cur_op];
            l = op_lens[cur_op];
            // zero-length op still eats one step
            r = (l > in_op) ? l - in_op : 1;
            if (is_match_kind(t) || t == caw_pkg::OP_D || t == caw_pkg::OP_N
                || t == caw_pkg::OP_H)
            begin
                n = (r < count) ? r : count;
                if (is_match_kind(t))
                    seq_pos = seq_advance(seq_pos, n);
                if (t == caw_pkg::OP_D)
                    indel_f = 1;
                cursor = cursor + 32'(n);
                count = count - n;
                in_op = in_op + n;
                if (in_op >= l)
                begin
                    in_op = 0;
                    cur_op++;
                end
            end
            else
            begin
                // I, S, P and unknown kinds are hopped in one go
                if (t == caw_pkg::OP_I || t == caw_pkg::OP_S)
                    seq_pos = seq_advance(seq_pos, r);
                if (t == caw_pkg::OP_I)
                    indel_f = 1;
                in_op = 0;
                cur_op++;
            end
        end
        while (cur_op < n_ops && (op_kinds[cur_op] == caw_pkg::OP_P
               || op_kinds[cur_op] == caw_pkg::OP_I))
        begin
            if (op_kinds[cur_op] == caw_pkg::OP_I)
            begin
                indel_f = 1;
                seq_pos = seq_advance(seq_pos, op_lens[cur_op]);
            end
            cur_op++;
        end
        if (cur_op >= n_ops)
            at_end_f = 1;
        else if (op_kinds[cur_op] == caw_pkg::OP_S || op_kinds[cur_op] == caw_pkg::OP_H)
        begin
            cur_op = n_ops;
            at_end_f = 1;
        end
    endfunction

    function automatic logic [1:0] scan_next_indel();
        logic [3:0] t;
        longint unsigned l;
        longint a;
        longint b;
        want.dist_five = clamp12(-1);
        want.dist_three = clamp12(-1);
        if (strand == caw_pkg::STR_UNK)
            return caw_pkg::ST_OK;
        if (!parse_f)
        begin
            // must have walked to the end before indel scanning starts
            if (cur_op != n_ops)
                return caw_pkg::ST_INDEL_EARLY;
            parse_f = 1;
            cur_op = 0;
            seq_pos = 0;
            cursor = {1'b0, start_pos};
        end
        while (cur_op < n_ops && op_kinds[cur_op] != caw_pkg::OP_I
               && op_kinds[cur_op] != caw_pkg::OP_D)
        begin
            t = op_kinds[cur_op];
            l = op_lens[cur_op];
            if (is_match_kind(t) || t == caw_pkg::OP_S)
                seq_pos = seq_advance(seq_pos, l);
            if (is_match_kind(t) || t == caw_pkg::OP_N || t == caw_pkg::OP_H)
                cursor = cursor + 32'(l);
            cur_op++;
        end
        if (cur_op >= n_ops)
            return caw_pkg::ST_OK;
        t = op_kinds[cur_op];
        l = op_lens[cur_op];
        want.indel_found = 1;
        want.indel_size = op_lens[cur_op];
        want.indel_genome_pos = cursor;
        want.indel_reverse = (strand == caw_pkg::STR_REV);
        a = seq_pos;
        b = longint'(read_length) - a;
        if (t == caw_pkg::OP_I)
        begin
            want.indel_insertion = 1;
            want.dist_five = clamp12(a);
            want.dist_three = clamp12(b - longint'(l));
            seq_pos = seq_advance(seq_pos, l);
        end
        else
        begin
            want.dist_five = clamp12(strand == caw_pkg::STR_FWD ? a : b);
            want.dist_three = clamp12(strand == caw_pkg::STR_FWD ? b : a);
            cursor = cursor + 32'(l);
        end
        cur_op++;
        return caw_pkg::ST_OK;
    endfunction

    // advances the model by one request and leaves its result in want
    function automatic void predict_walker(request_t q);
        logic [1:0] st;
        want = '0;
        st = caw_pkg::ST_OK;
        case (q.opc)
            caw_pkg::OPC_HEADER:
            begin
                start_pos = q.gpos;
                read_length = q.rlen;
                n_ops = 0;
                n_bases = 0;
                cur_op = 0;
                in_op = 0;
                seq_pos = 0;
                cursor = {1'b0, q.gpos};
                {at_end_f, indel_f, ign5_f, ign3_f, parse_f} = '0;
                strand = caw_pkg::STR_UNK;
                return;
            end
            caw_pkg::OPC_LOAD_OP:
            begin
                if (n_ops < OPS_MAX)
                begin
                    op_kinds[n_ops] = q.kind;
                    op_lens[n_ops] = q.len;
                    n_ops++;
                end
                return;
            end
            caw_pkg::OPC_LOAD_BASE:
            begin
                if (n_bases < BASES_MAX)
                begin
                    read_bases[n_bases] = q.base;
                    read_quals[n_bases] = q.qual;
                    n_bases++;
                end
                return;
            end
            caw_pkg::OPC_BEGIN:
            begin
                cur_op = 0;
                in_op = 0;
                seq_pos = 0;
                cursor = {1'b0, start_pos};
                {at_end_f, indel_f, ign5_f, ign3_f, parse_f} = '0;
                strand = caw_pkg::STR_UNK;
                // leading I, S and P are skipped
                while (cur_op < n_ops && (op_kinds[cur_op] == caw_pkg::OP_I
                       || op_kinds[cur_op] == caw_pkg::OP_S
                       || op_kinds[cur_op] == caw_pkg::OP_P))
                begin
                    if (op_kinds[cur_op] == caw_pkg::OP_I)
                        indel_f = 1;
                    if (op_kinds[cur_op] != caw_pkg::OP_P)
                        seq_pos = seq_advance(seq_pos, op_lens[cur_op]);
                    cur_op++;
                end
                if (cur_op >= n_ops)
                    at_end_f = 1;
                if (q.paired && q.proper)
                begin
                    if (q.first)
                    begin
                        ign3_f = 1;
                        strand = q.rev ? caw_pkg::STR_REV : caw_pkg::STR_FWD;
                    end
                    else if (q.second)
                    begin
                        ign5_f = 1;
                        strand = q.rev ? caw_pkg::STR_FWD : caw_pkg::STR_REV;
                    end
                end
                else if (!q.paired)
                    strand = q.rev ? caw_pkg::STR_REV : caw_pkg::STR_FWD;
                st = look_here();
            end
            caw_pkg::OPC_GO:
            begin
                if (longint'(q.gpos) < longint'(cursor))
                begin
                    st = look_here();
                    st = caw_pkg::ST_BACKWARD;
                end
                else
                begin
                    walk_forward(longint'(q.gpos) - longint'(cursor));
                    st = look_here();
                end
            end
            caw_pkg::OPC_NEXT_INDEL:
                st = scan_next_indel();
            default:
                return;
        endcase
        want.at_end = at_end_f;
        want.saw_indel = indel_f;
        want.status = st;
    endfunction

    function automatic logic [95:0] pack_request(request_t q);
        return {1'b0, q.rev, q.second, q.first, q.proper, q.paired, q.rlen, q.gpos,
                q.qual, q.base, q.len, q.kind};
    endfunction

    // idle gap (valid low) only when one is drawn, so valid is never
    // dropped and raised in the same step
    task automatic send_request(request_t q);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_request(q);
        s_tuser <= q.opc;
        do
            @(posedge clk);
        while (!s_tready);
        predict_walker(q);
        expected_results.push_back(want);
        items_sent++;
    endtask

    function automatic request_t blank_request(logic [2:0] opc);
        request_t q;
        q = '{default: '0};
        q.opc = opc;
        return q;
    endfunction

    task automatic send_header(logic [30:0] gpos, logic [10:0] rlen);
        request_t q;
        q = blank_request(caw_pkg::OPC_HEADER);
        q.gpos = gpos;
        q.rlen = rlen;
        q.kind = 4'($urandom);
        q.len = 28'($urandom);
        q.base = 8'($urandom);
        send_request(q);
    endtask

    task automatic send_op(logic [3:0] kind, logic [27:0] len);
        request_t q;
        q = blank_request(caw_pkg::OPC_LOAD_OP);
        q.kind = kind;
        q.len = len;
        q.gpos = 31'($urandom);
        send_request(q);
    endtask

    task automatic send_base(logic [7:0] base, logic [7:0] qual);
        request_t q;
        q = blank_request(caw_pkg::OPC_LOAD_BASE);
        q.base = base;
        q.qual = qual;
        send_request(q);
    endtask

    task automatic send_begin(logic [4:0] flags);
        request_t q;
        q = blank_request(caw_pkg::OPC_BEGIN);
        {q.rev, q.second, q.first, q.proper, q.paired} = flags;
        q.gpos = 31'($urandom);
        send_request(q);
    endtask

    task automatic send_go(logic [30:0] gpos);
        request_t q;
        q = blank_request(caw_pkg::OPC_GO);
        q.gpos = gpos;
        q.rlen = 11'($urandom);
        send_request(q);
    endtask

    task automatic send_plain(logic [2:0] opc);
        request_t q;
        q = blank_request(opc);
        q.len = 28'($urandom);
        send_request(q);
    endtask

    // flags packed {rev, second, first, proper, paired}
    localparam logic [4:0] PAIR_FIRST_REV = 5'b10111;
    localparam logic [4:0] PAIR_SECOND = 5'b01011;
    localparam logic [4:0] UNPAIRED_FWD = 5'b00000;
    localparam logic [4:0] UNPAIRED_REV = 5'b10000;
    localparam logic [4:0] PAIRED_IMPROPER = 5'b00101;
    localparam logic [4:0] PROPER_NO_MATE = 5'b00011;

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // APB write: setup then access, register takes the value at the access edge
    task automatic write_qoff(logic [7:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= PADDR_QOFF;
        pwdata <= {$urandom} & 32'hFFFF_FF00 | {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        qoff = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_header(31'd100, 11'd8);
        send_op(caw_pkg::OP_S, 28'd1);
        send_op(caw_pkg::OP_I, 28'd1);
        send_op(caw_pkg::OP_P, 28'd2);
        send_op(caw_pkg::OP_M, 28'd3);
        send_op(caw_pkg::OP_D, 28'd2);
        send_op(caw_pkg::OP_M, 28'd0);      // zero length still takes a step
        send_op(caw_pkg::OP_N, 28'd1);
        send_op(caw_pkg::OP_EQ, 28'd1);
        send_op(caw_pkg::OP_X, 28'd2);
        send_op(OP_UNKNOWN, 28'd1);
        send_op(caw_pkg::OP_H, 28'd5);
        send_base(8'h00, 8'hFF);
        send_base(8'hFF, 8'h00);
        send_base(8'h41, 8'h21);
        send_begin(PAIR_FIRST_REV); // leading S, I, P skipped
        send_go(31'd101);
        send_go(31'd100);           // backward
        send_go(31'd103);           // on the deletion
        send_plain(caw_pkg::OPC_NEXT_INDEL); // walk not at end yet
        send_go(31'd106);
        send_go(31'd108);           // resting spot is the X op
        send_go(31'h7FFF_FFFF);
        send_plain(caw_pkg::OPC_NEXT_INDEL);
        send_plain(caw_pkg::OPC_NEXT_INDEL);
        send_plain(caw_pkg::OPC_NEXT_INDEL);
        send_plain(OPC_SPARE6);
        send_plain(OPC_SPARE7);
        send_begin(PAIR_SECOND);
        send_go(31'd103);
        send_begin(PAIRED_IMPROPER);
        send_go(31'h7FFF_FFFF);
        send_plain(caw_pkg::OPC_NEXT_INDEL); // unknown strand: nothing found
        send_header(31'h7FFF_FFFF, 11'd1024);
        send_op(caw_pkg::OP_M, 28'hFFF_FFFF);
        send_op(caw_pkg::OP_I, 28'hFFF_FFFF);
        send_op(caw_pkg::OP_H, 28'hFFF_FFFF);
        send_begin(PROPER_NO_MATE);
        send_go(31'h7FFF_FFFF);
        send_begin(UNPAIRED_FWD);
        send_go(31'h7FFF_FFFF);
        send_plain(caw_pkg::OPC_NEXT_INDEL);
        send_plain(caw_pkg::OPC_NEXT_INDEL);
    endtask

    // more than the stores hold; the extra loads are dropped
    task automatic test_full_store();
        send_header(31'd5000, 11'd1024);
        for (int i = 0; i < OPS_MAX + 2; i++)
            send_op((i % 3 == 0) ? caw_pkg::OP_D : caw_pkg::OP_M,
                    28'($urandom_range(0, 20)));
        for (int i = 0; i < BASES_MAX + 3; i++)
            send_base(8'($urandom), 8'($urandom));
        send_begin(UNPAIRED_REV);
        for (int i = 0; i < 6; i++)
            send_go(31'(cursor + $urandom_range(0, 300)));
        send_go(31'h7FFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_plain(caw_pkg::OPC_NEXT_INDEL);
    endtask

    function automatic logic [3:0] pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return 4'($urandom_range(9, 15));
        if (r < 40)
            return caw_pkg::OP_M;
        return 4'($urandom_range(0, 8));
    endfunction

    // one read: header, ops, bases, an occasional spare opcode, begin, a run of go steps, indel scans
    task automatic random_read();
        int unsigned n_op, n_base, n_go;
        logic [30:0] gstart;
        logic [10:0] rlen;
        logic [27:0] len;
        gstart = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 100000));
        rlen = ($urandom_range(19) == 0) ? 11'($urandom_range(0, 1024))
                                         : 11'($urandom_range(0, 40));
        send_header(gstart, rlen);
        n_op = $urandom_range(0, 9);
        for (int i = 0; i < n_op; i++)
        begin
            len = ($urandom_range(29) == 0) ? 28'($urandom) : 28'($urandom_range(0, 12));
            send_op(pick_kind(), len);
        end
        n_base = ($urandom_range(9) == 0) ? $urandom_range(0, 60) : rlen % 41;
        for (int i = 0; i < n_base; i++)
            send_base(8'($urandom), 8'($urandom));
        if ($urandom_range(19) == 0)
            send_plain(3'($urandom_range(6, 7)));
        send_begin(5'($urandom));
        n_go = $urandom_range(0, 8);
        for (int i = 0; i < n_go; i++)
        begin
            case ($urandom_range(9))
                0: send_go(31'(cursor - $urandom_range(1, 5)));
                1: send_go(31'($urandom));
                default: send_go(31'(cursor + $urandom_range(0, 6)));
            endcase
        end
        if ($urandom_range(2) != 0)
            send_go(31'h7FFF_FFFF);
        for (int i = $urandom_range(0, 4); i > 0; i--)
            send_plain(caw_pkg::OPC_NEXT_INDEL);
    endtask

    task automatic test_random(int unsigned src_pct, int unsigned snk_pct, int unsigned count);
        int unsigned stop_at;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            random_read();
    endtask

    task automatic flag_mismatch(string field, longint unsigned got, longint unsigned exp);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", field, got, exp, cycles);
        errors++;
    endtask

    task automatic compare_result(caw_pkg::result_t got, caw_pkg::result_t exp);
        if (got.base_or_gap !== exp.base_or_gap)
            flag_mismatch("base_or_gap", got.base_or_gap, exp.base_or_gap);
        if (got.quality !== exp.quality)
            flag_mismatch("quality", got.quality, exp.quality);
        if (got.dist_five !== exp.dist_five)
            flag_mismatch("dist_five", got.dist_five, exp.dist_five);
        if (got.dist_three !== exp.dist_three)
            flag_mismatch("dist_three", got.dist_three, exp.dist_three);
        if (got.at_end !== exp.at_end)
            flag_mismatch("at_end", got.at_end, exp.at_end);
        if (got.saw_indel !== exp.saw_indel)
            flag_mismatch("saw_indel", got.saw_indel, exp.saw_indel);
        if (got.indel_found !== exp.indel_found)
            flag_mismatch("indel_found", got.indel_found, exp.indel_found);
        if (got.indel_insertion !== exp.indel_insertion)
            flag_mismatch("indel_insertion", got.indel_insertion, exp.indel_insertion);
        if (got.indel_size !== exp.indel_size)
            flag_mismatch("indel_size", got.indel_size, exp.indel_size);
        if (got.indel_genome_pos !== exp.indel_genome_pos)
            flag_mismatch("indel_genome_pos", got.indel_genome_pos, exp.indel_genome_pos);
        if (got.indel_reverse !== exp.indel_reverse)
            flag_mismatch("indel_reverse", got.indel_reverse, exp.indel_reverse);
        if (got.status !== exp.status)
            flag_mismatch("status", got.status, exp.status);
    endtask

    // receiver stall pattern
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    // result checker
    always @(posedge clk)
    begin
        caw_pkg::result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.base_or_gap = m_tdata[7:0];
            got.quality = m_tdata[16:8];
            got.dist_five = m_tdata[28:17];
            got.dist_three = m_tdata[40:29];
            got.at_end = m_tdata[41];
            got.saw_indel = m_tdata[42];
            got.indel_found = m_tdata[43];
            got.indel_insertion = m_tdata[44];
            got.indel_size = m_tdata[72:45];
            got.indel_genome_pos = m_tdata[104:73];
            got.indel_reverse = m_tdata[105];
            got.status = m_tdata[107:106];
            if (expected_results.size() == 0)
            begin
                $display("unexpected result %h at cycle %0d", m_tdata, cycles);
                errors++;
            end
            else
                compare_result(got, expected_results.pop_front());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();            // offset still at its reset value
        wait_idle();
        write_qoff(8'd0);
        test_full_store();
        wait_idle();
        write_qoff(8'd255);
        test_random(14, 50, 120);
        wait_idle();
        write_qoff(8'($urandom));
        test_random(50, 14, 120);
        wait_idle();
        write_qoff(8'd33);
        test_random(0, 0, 120);
        wait_idle();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
src/caw_pkg.sv
src/caw_ram.sv
src/caw_ctrl.sv
src/caw_datapath.sv
src/cigar_alignment_walker.sv
bench/tb_cigar_alignment_walker.sv
